>>> rtl/core/kpdr_pkg.sv
// Package for the key dead-time / auto-repeat block.
// Holds field widths, register indexes, reset values and the shared types.
// No dependencies.
package kpdr_pkg;

  // Fixed widths of the stream fields and registers
  localparam int TIME_W     = 24;
  localparam int TICK_W     = 16;
  localparam int COUNT_W    = 8;
  localparam int FIELD_KEYS = 4;
  localparam int IDX_W      = 3;

  localparam int IN_DATA_W  = 24;  // 16 + 4 bits, padded to whole bytes
  localparam int OUT_DATA_W = 8;

  localparam int NUM_KEYS_DEF = 4;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_PRESS_TIME      = 3'd0,
    REG_LONG_DEAD_TIME  = 3'd1,
    REG_SHORT_DEAD_TIME = 3'd2,
    REG_SCREEN_WINDOW   = 3'd3,
    REG_MIN_TRIGGERS    = 3'd4,
    REG_SHORT_DEAD_MASK = 3'd5
  } reg_idx_t;

  // Reset values of the registers
  localparam logic [TIME_W-1:0]     PRESS_TIME_RST      = 24'd50;
  localparam logic [TIME_W-1:0]     LONG_DEAD_TIME_RST  = 24'd500;
  localparam logic [TIME_W-1:0]     SHORT_DEAD_TIME_RST = 24'd100;
  localparam logic [TIME_W-1:0]     SCREEN_WINDOW_RST   = 24'd1000;
  localparam logic [COUNT_W-1:0]    MIN_TRIGGERS_RST    = 8'd3;
  localparam logic [FIELD_KEYS-1:0] SHORT_DEAD_MASK_RST = 4'd0;

  // Shared timing settings seen by every lane
  typedef struct packed {
    logic [TIME_W-1:0]  hold_lim;
    logic [TIME_W-1:0]  dead_long;
    logic [TIME_W-1:0]  dead_short;
    logic [TIME_W-1:0]  screen_window;
    logic [COUNT_W-1:0] min_triggers;
  } cfg_t;

  // Per-key phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_PRESSED = 3'b010,
    PH_DEAD    = 3'b100
  } phase_t;

  // Saturating 24-bit add of a tick to a timer
  function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                                input logic [TICK_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W-TICK_W+1){1'b0}}, b};
    add_sat = s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

>>> rtl/core/kpdr_lane.sv
// One key lane: phase machine, phase timer, screen timer and repeat count.
// Depends on kpdr_pkg.
module kpdr_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,        // tick transfer accepted
  input  logic [kpdr_pkg::TICK_W-1:0]   tick_elapsed,
  input  logic                          down,
  input  logic                          short_en,
  input  kpdr_pkg::cfg_t                cfg,
  output logic                          trigger,
  output logic                          fast_mode
);

  kpdr_pkg::phase_t                    phase_r, phase_nxt;
  logic [kpdr_pkg::TIME_W-1:0]         phase_tmr_r, phase_tmr_nxt;
  logic [kpdr_pkg::TIME_W-1:0]         scr_tmr_r, scr_tmr_nxt;
  logic [kpdr_pkg::COUNT_W-1:0]        rpt_cnt_r, rpt_cnt_nxt;

  logic [kpdr_pkg::TIME_W-1:0]         phase_sum;
  logic [kpdr_pkg::TIME_W-1:0]         hold_sum;
  logic [kpdr_pkg::TIME_W-1:0]         dead_sel;
  logic                                fire;

  // Both candidate hold times in parallel: continuing press or fresh press
  assign phase_sum = kpdr_pkg::add_sat(phase_tmr_r, tick_elapsed);
  assign hold_sum  = (phase_r == kpdr_pkg::PH_PRESSED) ? phase_sum
                   : {{(kpdr_pkg::TIME_W-kpdr_pkg::TICK_W){1'b0}}, tick_elapsed};

  // Next state for one tick
  always_comb begin
    phase_nxt     = phase_r;
    phase_tmr_nxt = phase_tmr_r;
    rpt_cnt_nxt   = rpt_cnt_r;
    fire          = 1'b0;

    // screen timer runs only while a repeat run is counted
    scr_tmr_nxt = (rpt_cnt_r == '0) ? '0 : kpdr_pkg::add_sat(scr_tmr_r, tick_elapsed);

    dead_sel = (short_en && (rpt_cnt_r >= cfg.min_triggers)) ? cfg.dead_short
                                                             : cfg.dead_long;

    // dead time expiry
    if (phase_r == kpdr_pkg::PH_DEAD) begin
      phase_tmr_nxt = phase_sum;
      if (phase_sum > dead_sel) begin
        phase_nxt     = kpdr_pkg::PH_IDLE;
        phase_tmr_nxt = '0;
      end
    end

    // release while pressed
    if (phase_nxt == kpdr_pkg::PH_PRESSED && !down) begin
      phase_nxt     = kpdr_pkg::PH_IDLE;
      phase_tmr_nxt = '0;
    end

    // new press
    if (down && phase_nxt == kpdr_pkg::PH_IDLE) begin
      phase_nxt     = kpdr_pkg::PH_PRESSED;
      phase_tmr_nxt = '0;
    end

    // idle gap clears the run, otherwise a held key accumulates hold time
    if (phase_nxt == kpdr_pkg::PH_IDLE && scr_tmr_nxt > cfg.screen_window) begin
      rpt_cnt_nxt = '0;
      scr_tmr_nxt = '0;
    end else if (down && phase_nxt == kpdr_pkg::PH_PRESSED) begin
      phase_tmr_nxt = hold_sum;
      if (hold_sum > cfg.hold_lim) begin
        fire = 1'b1;
        if (rpt_cnt_r < cfg.min_triggers) begin
          rpt_cnt_nxt = rpt_cnt_r + 1'b1;
        end
        phase_nxt     = kpdr_pkg::PH_DEAD;
        phase_tmr_nxt = '0;
      end
    end

    // run dropped when the window passes before fast mode is reached
    if (scr_tmr_nxt > cfg.screen_window && rpt_cnt_nxt < cfg.min_triggers) begin
      rpt_cnt_nxt = '0;
    end
  end

  assign trigger   = fire;
  assign fast_mode = (rpt_cnt_nxt >= cfg.min_triggers);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= kpdr_pkg::PH_IDLE;
      phase_tmr_r <= '0;
      scr_tmr_r   <= '0;
      rpt_cnt_r   <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      phase_tmr_r <= phase_tmr_nxt;
      scr_tmr_r   <= scr_tmr_nxt;
      rpt_cnt_r   <= rpt_cnt_nxt;
    end
  end

endmodule

>>> rtl/core/kpdr_merge.sv
// Merge stage: gathers the lane flags into one result and holds it in an
// output register with a skid stage. Depends on kpdr_pkg.
module kpdr_merge #(
  parameter int NUM_KEYS = kpdr_pkg::NUM_KEYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [NUM_KEYS-1:0]               lane_trig,
  input  logic [NUM_KEYS-1:0]               lane_fast,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kpdr_pkg::OUT_DATA_W-1:0]   out_data
);

  localparam int FK = kpdr_pkg::FIELD_KEYS;

  logic [FK-1:0]                      trig_bits;
  logic [FK-1:0]                      fast_bits;
  logic [kpdr_pkg::OUT_DATA_W-1:0]    res;
  logic                               out_valid_r, skid_valid_r;
  logic [kpdr_pkg::OUT_DATA_W-1:0]    out_data_r, skid_data_r;
  logic                               push, pop;

  // Keys beyond the field width are dropped, missing keys read as zero
  for (genvar i = 0; i < FK; i++) begin : g_bits
    if (i < NUM_KEYS) begin : g_have
      assign trig_bits[i] = lane_trig[i];
      assign fast_bits[i] = lane_fast[i];
    end else begin : g_none
      assign trig_bits[i] = 1'b0;
      assign fast_bits[i] = 1'b0;
    end
  end

  assign res      = {fast_bits, trig_bits};
  assign in_ready = !skid_valid_r;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;

  // Output register plus skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (push) begin
      skid_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/key_press_deadtime_repeat.sv
// Key debounce with dead time and auto-repeat acceleration, top level.
// Holds the configuration registers; instantiates kpdr_lane and kpdr_merge.
// Depends on kpdr_pkg.
//
// One tick transfer is taken every clock cycle while in_tready is high: all
// keys are updated side by side, one lane per key, in the cycle the tick is
// accepted, and the result (trigger and fast-mode masks) is registered in the
// output register. A skid stage behind the output register lets one further
// tick in while the result waits; in_tready drops only when both are full. The
// per-lane 24-bit add and compare chain sets the clock limit.
module key_press_deadtime_repeat #(
  parameter int NUM_KEYS = kpdr_pkg::NUM_KEYS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // tick input
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [kpdr_pkg::IN_DATA_W-1:0]      in_tdata,   // tick_elapsed[15:0], pressed_bits[19:16]
  // result output
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [kpdr_pkg::OUT_DATA_W-1:0]     out_tdata,  // trigger_bits[3:0], fast_mode_bits[7:4]
  // configuration writes
  input  logic                                cfg_we,
  input  logic [kpdr_pkg::IDX_W-1:0]          cfg_index,
  input  logic [kpdr_pkg::TIME_W-1:0]         cfg_wdata
);

  localparam int FK = kpdr_pkg::FIELD_KEYS;

  kpdr_pkg::cfg_t                 cfg_r;
  logic [FK-1:0]                  short_mask_r;
  logic [kpdr_pkg::TICK_W-1:0]    tick_elapsed;
  logic [FK-1:0]                  pressed_bits;
  logic                           step;
  logic [NUM_KEYS-1:0]            lane_trig;
  logic [NUM_KEYS-1:0]            lane_fast;

  assign tick_elapsed = in_tdata[kpdr_pkg::TICK_W-1:0];
  assign pressed_bits = in_tdata[kpdr_pkg::TICK_W +: FK];
  assign step         = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_lim      <= kpdr_pkg::PRESS_TIME_RST;
      cfg_r.dead_long     <= kpdr_pkg::LONG_DEAD_TIME_RST;
      cfg_r.dead_short    <= kpdr_pkg::SHORT_DEAD_TIME_RST;
      cfg_r.screen_window <= kpdr_pkg::SCREEN_WINDOW_RST;
      cfg_r.min_triggers  <= kpdr_pkg::MIN_TRIGGERS_RST;
      short_mask_r        <= kpdr_pkg::SHORT_DEAD_MASK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kpdr_pkg::REG_PRESS_TIME:      cfg_r.hold_lim      <= cfg_wdata;
        kpdr_pkg::REG_LONG_DEAD_TIME:  cfg_r.dead_long     <= cfg_wdata;
        kpdr_pkg::REG_SHORT_DEAD_TIME: cfg_r.dead_short    <= cfg_wdata;
        kpdr_pkg::REG_SCREEN_WINDOW:   cfg_r.screen_window <= cfg_wdata;
        kpdr_pkg::REG_MIN_TRIGGERS:
          cfg_r.min_triggers <= cfg_wdata[kpdr_pkg::COUNT_W-1:0];
        kpdr_pkg::REG_SHORT_DEAD_MASK: short_mask_r <= cfg_wdata[FK-1:0];
        default: ;
      endcase
    end
  end

  // One lane per key; keys beyond the field read as released
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic down_k;
    logic short_k;

    if (k < FK) begin : g_in
      assign down_k  = pressed_bits[k];
      assign short_k = short_mask_r[k];
    end else begin : g_out
      assign down_k  = 1'b0;
      assign short_k = 1'b0;
    end

    kpdr_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .step         (step),
      .tick_elapsed (tick_elapsed),
      .down         (down_k),
      .short_en     (short_k),
      .cfg          (cfg_r),
      .trigger      (lane_trig[k]),
      .fast_mode    (lane_fast[k])
    );
  end

  kpdr_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .lane_trig (lane_trig),
    .lane_fast (lane_fast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
